// ----- rtl/mpo_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor position observer package
// Widths, fixed-point constants and the command and status types shared by
// the controller, the datapath and the channel interfaces.
// ----------------------------------------------------------------------------
package mpo_pkg;

    // Width of the saturating signal path (speed integrator and torque sum).
    localparam int DW = 32;

    localparam int ANGLE_W     = 19;
    localparam int TORQUE_W    = 32;
    localparam int OUT_W       = 32;
    localparam int LOAD_W      = 32;
    localparam int GAIN31_W    = 31;
    localparam int GAIN32_W    = 32;
    localparam int IPP_W       = 17;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Pi and two pi as unsigned Q3.16 angles.
    localparam logic [ANGLE_W-1:0] PI_Q  = ANGLE_W'(205887);
    localparam logic [ANGLE_W-1:0] TAU_Q = ANGLE_W'(411775);

    // Wrapped angle error and mechanical error, both signed.
    localparam int ERR_W  = ANGLE_W + 2;
    localparam int MECH_W = ANGLE_W + 2;

    // Working width of the saturating sums before clamping to DW bits.
    localparam int SW = (DW > 36) ? DW + 2 : 38;

    // Angle reduction: an offset of whole turns makes the sum non-negative,
    // then a reciprocal multiply estimates the number of turns.
    localparam int UW = DW + 1;
    localparam int QW = UW - 18;
    localparam longint unsigned TAU_L   = 64'd411775;
    localparam longint unsigned MOD_K   = ((64'd1 << (DW - 1)) + TAU_L - 64'd1) / TAU_L;
    localparam longint unsigned MOD_OFF = MOD_K * TAU_L;
    localparam longint unsigned MOD_M   = (64'd1 << UW) / TAU_L;

    // Shared multiplier operand and product widths.
    localparam int AW = UW + 1;
    localparam int BW = GAIN32_W + 1;
    localparam int PW = AW + BW;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN_SPEED_FF   = 3'd0,
        CFG_GAIN_PROP       = 3'd1,
        CFG_GAIN_INT_DT     = 3'd2,
        CFG_INV_INERTIA_DT  = 3'd3,
        CFG_INV_POLE_PAIRS  = 3'd4,
        CFG_ELECTRICAL_DT   = 3'd5,
        CFG_TORQUE_LIMIT    = 3'd6,
        CFG_OBSERVER_ENABLE = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_MECH,
        MUL_LI,
        MUL_P,
        MUL_I,
        MUL_F,
        MUL_E,
        MUL_Q,
        MUL_R
    } mul_sel_t;

    typedef enum logic [3:0] {
        UPD_NONE,
        UPD_ERR,
        UPD_MECH,
        UPD_LOAD,
        UPD_SUM,
        UPD_SPEED,
        UPD_SOUT,
        UPD_ANG,
        UPD_WRAP
    } upd_sel_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        upd_sel_t upd_sel;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic enable;
    } dp_status_t;

endpackage

// ----- rtl/mpo_in_if.sv -----
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one measured angle and one torque per transfer.
// ----------------------------------------------------------------------------
interface mpo_in_if import mpo_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic        [ANGLE_W-1:0]  measured_angle;
    logic signed [TORQUE_W-1:0] electrical_torque;

    modport source (
        output valid,
        output measured_angle,
        output electrical_torque,
        input  ready
    );

    modport sink (
        input  valid,
        input  measured_angle,
        input  electrical_torque,
        output ready
    );

endinterface

// ----- rtl/mpo_out_if.sv -----
// ----------------------------------------------------------------------------
// Estimate channel
// Valid/ready channel carrying one set of observer estimates per transfer.
// ----------------------------------------------------------------------------
interface mpo_out_if import mpo_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic        [ANGLE_W-1:0] estimated_angle;
    logic signed [OUT_W-1:0] estimated_speed;
    logic signed [OUT_W-1:0] estimated_load_torque;
    logic signed [OUT_W-1:0] total_torque;

    modport source (
        output valid,
        output estimated_angle,
        output estimated_speed,
        output estimated_load_torque,
        output total_torque,
        input  ready
    );

    modport sink (
        input  valid,
        input  estimated_angle,
        input  estimated_speed,
        input  estimated_load_torque,
        input  total_torque,
        output ready
    );

endinterface

// ----- rtl/mpo_ctrl.sv -----
// ----------------------------------------------------------------------------
// Motor position observer controller
// One-hot sequencer that steps the datapath through one observer update and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module mpo_ctrl import mpo_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [17:0] {
        ST_IDLE     = 18'h00001,
        ST_ERR      = 18'h00002,
        ST_MUL_MECH = 18'h00004,
        ST_MECH     = 18'h00008,
        ST_MUL_LI   = 18'h00010,
        ST_LOAD     = 18'h00020,
        ST_MUL_P    = 18'h00040,
        ST_SUM      = 18'h00080,
        ST_MUL_I    = 18'h00100,
        ST_SPEED    = 18'h00200,
        ST_MUL_F    = 18'h00400,
        ST_SOUT     = 18'h00800,
        ST_MUL_E    = 18'h01000,
        ST_ANG      = 18'h02000,
        ST_MUL_Q    = 18'h04000,
        ST_MUL_R    = 18'h08000,
        ST_WRAP     = 18'h10000,
        ST_DONE     = 18'h20000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.mul_sel  = MUL_NONE;
        cmd.upd_sel  = UPD_NONE;
        cmd.load_out = 1'b0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.enable ? ST_ERR : ST_DONE;
                end
            end
            ST_ERR:
            begin
                cmd.upd_sel = UPD_ERR;
                state_next  = ST_MUL_MECH;
            end
            ST_MUL_MECH:
            begin
                cmd.mul_sel = MUL_MECH;
                state_next  = ST_MECH;
            end
            ST_MECH:
            begin
                cmd.upd_sel = UPD_MECH;
                state_next  = ST_MUL_LI;
            end
            ST_MUL_LI:
            begin
                cmd.mul_sel = MUL_LI;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.upd_sel = UPD_LOAD;
                state_next  = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_sel = MUL_P;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.upd_sel = UPD_SUM;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_sel = MUL_I;
                state_next  = ST_SPEED;
            end
            ST_SPEED:
            begin
                cmd.upd_sel = UPD_SPEED;
                state_next  = ST_MUL_F;
            end
            ST_MUL_F:
            begin
                cmd.mul_sel = MUL_F;
                state_next  = ST_SOUT;
            end
            ST_SOUT:
            begin
                cmd.upd_sel = UPD_SOUT;
                state_next  = ST_MUL_E;
            end
            ST_MUL_E:
            begin
                cmd.mul_sel = MUL_E;
                state_next  = ST_ANG;
            end
            ST_ANG:
            begin
                cmd.upd_sel = UPD_ANG;
                state_next  = ST_MUL_Q;
            end
            ST_MUL_Q:
            begin
                cmd.mul_sel = MUL_Q;
                state_next  = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                cmd.mul_sel = MUL_R;
                state_next  = ST_WRAP;
            end
            ST_WRAP:
            begin
                cmd.upd_sel = UPD_WRAP;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/mpo_datapath.sv -----
// ----------------------------------------------------------------------------
// Motor position observer datapath
// Configuration registers, observer state, one shared signed multiplier with
// a registered product, and the add, clamp and wrap logic around it.
// ----------------------------------------------------------------------------
module mpo_datapath import mpo_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic        [CFG_INDEX_W-1:0] cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data,
    input  logic        [ANGLE_W-1:0]    measured_angle,
    input  logic signed [TORQUE_W-1:0]   electrical_torque,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    output logic        [ANGLE_W-1:0]    estimated_angle,
    output logic signed [OUT_W-1:0]      estimated_speed,
    output logic signed [OUT_W-1:0]      estimated_load_torque,
    output logic signed [OUT_W-1:0]      total_torque
);

    localparam logic signed [ERR_W-1:0] PI_S  = ERR_W'(PI_Q);
    localparam logic signed [ERR_W-1:0] TAU_S = ERR_W'(TAU_Q);

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
        logic [SW-DW:0] upper;
        upper = v[SW-1:DW-1];
        if ((&upper) || (~|upper))
        begin
            return v[DW-1:0];
        end
        else if (v[SW-1])
        begin
            return {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    // Configuration registers.
    logic [GAIN31_W-1:0] gain_speed_ff_reg;
    logic [GAIN31_W-1:0] gain_prop_reg;
    logic [GAIN32_W-1:0] gain_int_dt_reg;
    logic [GAIN32_W-1:0] inv_inertia_dt_reg;
    logic [IPP_W-1:0]    inv_pole_pairs_reg;
    logic [GAIN32_W-1:0] electrical_dt_reg;
    logic [GAIN31_W-1:0] torque_limit_reg;
    logic                enable_reg;

    // Observer state.
    logic                     seeded_reg;
    logic        [ANGLE_W-1:0] angle_reg;
    logic signed [LOAD_W-1:0] load_reg;
    logic signed [LOAD_W-1:0] load_hold_reg;
    logic signed [DW-1:0]     tsum_reg;
    logic signed [DW-1:0]     speed_reg;
    logic signed [DW-1:0]     sout_reg;

    // Per-sample working registers.
    logic        [ANGLE_W-1:0]  meas_reg;
    logic signed [TORQUE_W-1:0] torque_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [MECH_W-1:0]   mech_reg;
    logic        [UW-1:0]       u_reg;
    logic signed [PW-1:0]       p_reg;

    // Output payload.
    logic        [ANGLE_W-1:0] out_angle_reg;
    logic signed [OUT_W-1:0]   out_speed_reg;
    logic signed [OUT_W-1:0]   out_load_reg;
    logic signed [OUT_W-1:0]   out_tsum_reg;

    // Multiplier operands.
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;

    // Next values.
    logic signed [ERR_W-1:0]  err_diff;
    logic signed [ERR_W-1:0]  err_next;
    logic signed [MECH_W-1:0] load_inc;
    logic signed [LOAD_W:0]   load_sum;
    logic signed [LOAD_W:0]   load_lim;
    logic signed [LOAD_W:0]   load_clamp;
    logic signed [LOAD_W-1:0] load_next;
    logic signed [LOAD_W-1:0] load_hold_next;
    logic signed [DW-1:0]     tsum_next;
    logic signed [DW-1:0]     speed_next;
    logic signed [DW-1:0]     sout_next;
    logic signed [UW:0]       ang_sum;
    logic        [UW-1:0]     u_next;
    logic        [ANGLE_W:0]  rem_diff;
    logic        [ANGLE_W:0]  rem_wrap;
    logic        [ANGLE_W-1:0] angle_next;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_MECH:
            begin
                mul_a = AW'(err_reg);
                mul_b = signed'(BW'(inv_pole_pairs_reg));
            end
            MUL_LI:
            begin
                mul_a = AW'(mech_reg);
                mul_b = signed'(BW'(gain_int_dt_reg));
            end
            MUL_P:
            begin
                mul_a = AW'(mech_reg);
                mul_b = signed'(BW'(gain_prop_reg));
            end
            MUL_I:
            begin
                mul_a = AW'(tsum_reg);
                mul_b = signed'(BW'(inv_inertia_dt_reg));
            end
            MUL_F:
            begin
                mul_a = AW'(mech_reg);
                mul_b = signed'(BW'(gain_speed_ff_reg));
            end
            MUL_E:
            begin
                mul_a = AW'(sout_reg);
                mul_b = signed'(BW'(electrical_dt_reg));
            end
            MUL_Q:
            begin
                mul_a = signed'(AW'(u_reg));
                mul_b = signed'(BW'(MOD_M));
            end
            MUL_R:
            begin
                mul_a = signed'(AW'(p_reg[UW +: QW]));
                mul_b = signed'(BW'(TAU_Q));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        err_diff = ERR_W'(signed'({1'b0, meas_reg})) - ERR_W'(signed'({1'b0, angle_reg}));
        if (err_diff > PI_S)
        begin
            err_next = err_diff - TAU_S;
        end
        else if (err_diff < -PI_S)
        begin
            err_next = err_diff + TAU_S;
        end
        else
        begin
            err_next = err_diff;
        end

        load_inc = signed'(p_reg[32 +: MECH_W]);
        load_sum = (LOAD_W+1)'(load_reg) + (LOAD_W+1)'(load_inc);
        load_lim = signed'((LOAD_W+1)'(torque_limit_reg));
        if (load_sum > load_lim)
        begin
            load_clamp = load_lim;
        end
        else if (load_sum < -load_lim)
        begin
            load_clamp = -load_lim;
        end
        else
        begin
            load_clamp = load_sum;
        end
        load_next      = signed'(load_clamp[LOAD_W-1:0]);
        load_hold_next = -load_next;

        tsum_next  = sat_dw(SW'(torque_reg) + signed'(p_reg[16 +: SW]) + SW'(load_reg));
        speed_next = sat_dw(SW'(speed_reg) + SW'(signed'(p_reg[32 +: DW])));
        sout_next  = sat_dw(signed'(p_reg[16 +: SW]) + SW'(speed_reg));

        ang_sum = (UW+1)'(signed'({1'b0, angle_reg})) + (UW+1)'(signed'(p_reg[32 +: DW]))
                  + signed'((UW+1)'(MOD_OFF));
        u_next  = ang_sum[UW-1:0];

        // The turn estimate is at most one low, so one subtract finishes it.
        rem_diff = u_reg[ANGLE_W:0] - p_reg[ANGLE_W:0];
        if (rem_diff >= (ANGLE_W+1)'(TAU_Q))
        begin
            rem_wrap = rem_diff - (ANGLE_W+1)'(TAU_Q);
        end
        else
        begin
            rem_wrap = rem_diff;
        end
        angle_next = rem_wrap[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_speed_ff_reg  <= '0;
            gain_prop_reg      <= '0;
            gain_int_dt_reg    <= '0;
            inv_inertia_dt_reg <= '0;
            inv_pole_pairs_reg <= IPP_W'(65536);
            electrical_dt_reg  <= '0;
            torque_limit_reg   <= '0;
            enable_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_SPEED_FF:   gain_speed_ff_reg  <= cfg_data[GAIN31_W-1:0];
                CFG_GAIN_PROP:       gain_prop_reg      <= cfg_data[GAIN31_W-1:0];
                CFG_GAIN_INT_DT:     gain_int_dt_reg    <= cfg_data[GAIN32_W-1:0];
                CFG_INV_INERTIA_DT:  inv_inertia_dt_reg <= cfg_data[GAIN32_W-1:0];
                CFG_INV_POLE_PAIRS:  inv_pole_pairs_reg <= cfg_data[IPP_W-1:0];
                CFG_ELECTRICAL_DT:   electrical_dt_reg  <= cfg_data[GAIN32_W-1:0];
                CFG_TORQUE_LIMIT:    torque_limit_reg   <= cfg_data[GAIN31_W-1:0];
                CFG_OBSERVER_ENABLE: enable_reg         <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg    <= 1'b0;
            angle_reg     <= '0;
            load_reg      <= '0;
            load_hold_reg <= '0;
            tsum_reg      <= '0;
            speed_reg     <= '0;
            sout_reg      <= '0;
        end
        else
        begin
            if (cmd.capture && !seeded_reg)
            begin
                angle_reg  <= measured_angle;
                seeded_reg <= 1'b1;
            end
            case (cmd.upd_sel)
                UPD_LOAD:
                begin
                    load_reg      <= load_next;
                    load_hold_reg <= load_hold_next;
                end
                UPD_SUM:   tsum_reg  <= tsum_next;
                UPD_SPEED: speed_reg <= speed_next;
                UPD_SOUT:  sout_reg  <= sout_next;
                UPD_WRAP:  angle_reg <= angle_next;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            meas_reg   <= measured_angle;
            torque_reg <= electrical_torque;
        end
        if (cmd.upd_sel == UPD_ERR)
        begin
            err_reg <= err_next;
        end
        if (cmd.upd_sel == UPD_MECH)
        begin
            mech_reg <= signed'(p_reg[16 +: MECH_W]);
        end
        if (cmd.upd_sel == UPD_ANG)
        begin
            u_reg <= u_next;
        end
        if (cmd.mul_sel != MUL_NONE)
        begin
            p_reg <= PW'(mul_a) * PW'(mul_b);
        end
        if (cmd.load_out)
        begin
            out_angle_reg <= angle_reg;
            out_speed_reg <= OUT_W'(sout_reg);
            out_load_reg  <= OUT_W'(load_hold_reg);
            out_tsum_reg  <= OUT_W'(tsum_reg);
        end
    end

    assign status.enable         = enable_reg;
    assign estimated_angle       = out_angle_reg;
    assign estimated_speed       = out_speed_reg;
    assign estimated_load_torque = out_load_reg;
    assign total_torque          = out_tsum_reg;

endmodule

// ----- rtl/motor_position_observer_unit.sv -----
// ----------------------------------------------------------------------------
// Motor position observer unit
// Luenberger speed and position observer for a permanent-magnet motor.
// ----------------------------------------------------------------------------
// Each transfer on the sample channel brings a measured electrical angle in
// Q3.16 and an electromagnetic torque in Q16.16 and produces exactly one
// transfer on the estimate channel. The first sample after reset seeds the
// angle estimate. With the observer enabled, the sequencer runs all eight
// products of one update through a single shared multiplier with a
// registered product, alternating multiply and accumulate steps but for the
// two back-to-back products of the angle wrap. The estimates enter the output
// register as the sequencer returns to wait for the next sample. With the
// observer disabled the outputs repeat the held estimates. A new sample is
// taken while the previous estimates still wait in the output register; the
// sequencer only stalls at its last step if they are still untaken then.
// Configuration writes take effect at the clock edge of the write and must
// be made while no sample is in flight.
// ----------------------------------------------------------------------------
module motor_position_observer_unit import mpo_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    mpo_in_if.sink                 sample,
    mpo_out_if.source              result
);

    // Commands from the sequencer to the datapath, and the datapath status
    // that the sequencer branches on.
    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller owns both handshakes. Ready on the sample channel is
    // high only while the sequencer waits for a new sample, and the estimate
    // channel's valid comes straight from the output register's flag.
    mpo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the configuration registers, the observer state and
    // the registered estimate payload that the estimate channel presents.
    mpo_datapath u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .measured_angle        (sample.measured_angle),
        .electrical_torque     (sample.electrical_torque),
        .cmd                   (cmd),
        .status                (status),
        .estimated_angle       (result.estimated_angle),
        .estimated_speed       (result.estimated_speed),
        .estimated_load_torque (result.estimated_load_torque),
        .total_torque          (result.total_torque)
    );

    // A sample transfer starts an update, so the channel must close at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("sample channel stayed open after a transfer");

    // The datapath captures a sample only on an actual transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (sample.valid && sample.ready))
        else $error("sample captured without a transfer");

    // New estimates never overwrite ones that are still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result.valid || result.ready))
        else $error("estimate register overwritten before its transfer");

    // The sequencer never multiplies and captures in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (cmd.mul_sel == MUL_NONE && cmd.upd_sel == UPD_NONE))
        else $error("capture overlapped a datapath step");

endmodule
